// ----- hdl/sdtp_pkg.sv -----
// Shared types and constants for the delay timer pool.
// Field widths, command codes and the request/response item structs.
// No dependencies.
package sdtp_pkg;

	localparam int MODE_W    = 3;
	localparam int CHAN_W    = 2;
	localparam int SLOT_W    = 4;
	localparam int DELAY_W   = 16;
	localparam int GRANT_W   = 4;

	// command codes carried in the mode field
	typedef enum logic [MODE_W-1:0] {
		MODE_TICK    = 3'd0,
		MODE_ALLOC   = 3'd1,
		MODE_QUERY   = 3'd2,
		MODE_RELEASE = 3'd3,
		MODE_RESTART = 3'd4,
		MODE_CLEAR   = 3'd5
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [CHAN_W-1:0]  channel;
		logic [SLOT_W-1:0]  slot;
		logic [DELAY_W-1:0] delay;
	} req_item_t;

	typedef struct packed {
		logic [GRANT_W-1:0] granted_slot;
		logic               alloc_failed;
		logic               done_res;
	} rsp_item_t;

	// per-slot update command
	typedef struct packed {
		logic               tick;
		logic               load;
		logic               clr;
		logic [DELAY_W-1:0] delay;
	} cell_cmd_t;

	// per-slot status
	typedef struct packed {
		logic busy;
		logic expired;
	} cell_stat_t;

endpackage

// ----- hdl/sdtp_chan_if.sv -----
// Valid/ready channel interface for the delay timer pool.
// Payload type is a parameter; used with sdtp_pkg item structs.
interface sdtp_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/sdtp_cell.sv -----
// One countdown slot: remaining count, busy and done flags.
// Depends on sdtp_pkg for the command and status structs.
module sdtp_cell import sdtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	output cell_stat_t stat
);
	logic [DELAY_W-1:0] remaining_q;
	logic               busy_q;
	logic               expired_q;
	logic [DELAY_W-1:0] dec;

	// count down only while busy and not yet at zero
	always_comb begin
		dec = remaining_q;
		if (busy_q && (remaining_q != '0))
			dec = remaining_q - DELAY_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			busy_q      <= 1'b0;
			expired_q   <= 1'b0;
		end else if (cmd.clr) begin
			remaining_q <= '0;
			busy_q      <= 1'b0;
			expired_q   <= 1'b0;
		end else if (cmd.load) begin
			remaining_q <= cmd.delay;
			busy_q      <= 1'b1;
			expired_q   <= 1'b0;
		end else if (cmd.tick) begin
			remaining_q <= dec;
			if (busy_q && (dec == '0))
				expired_q <= 1'b1;
		end
	end

	assign stat.busy    = busy_q;
	assign stat.expired = expired_q;
endmodule

// ----- hdl/sdtp_alloc.sv -----
// Lowest-free-slot finder for the delay timer pool.
// Isolates the lowest set bit of the free mask and encodes it. No package use.
module sdtp_alloc #(
	parameter int SLOTS = 16,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic [SLOTS-1:0] free,
	output logic             found,
	output logic [IW-1:0]    index
);
	logic [SLOTS-1:0] lowest;

	// two's complement trick keeps only the lowest free bit
	assign lowest = free & (~free + SLOTS'(1));
	assign found  = |free;

	// one-hot to binary, each output bit an OR of independent terms
	always_comb begin
		index = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (lowest[i])
				index = index | IW'(i);
		end
	end
endmodule

// ----- hdl/software_delay_timer_pool.sv -----
// Top level of the delay timer pool: slot cells, allocator and the
// request/response registers. Depends on sdtp_pkg, sdtp_chan_if, sdtp_cell, sdtp_alloc.
//
// Usage:
//   req carries one command per transaction (tick, allocate, query done,
//   release, restart, clear channel) addressed to a channel and slot.
//   rsp returns exactly one result per command, in order: granted slot and
//   failure flag for allocate, done flag for query, zeros otherwise.
// Pipeline: a command is held in the input register, then applied to the slot state as
//   its result is captured in the result register and presented on rsp (two register stages).
// Throughput: one command per cycle while rsp is not held off; a whole channel is
//   ticked, cleared or searched for a free slot at once by per-slot cells and a
//   one-hot priority encoder.
// Stall: while rsp is held off, the result register keeps its transaction
//   and one more command waits in the input register; req.ready then drops.
// Reset: arst_n clears every slot (free, zero count, done clear) and
//   empties both registers at once; no sweep is needed.
module software_delay_timer_pool import sdtp_pkg::*; #(
	parameter int SLOTS    = 16,
	parameter int CHANNELS = 4
) (
	input logic       clk,
	input logic       arst_n,
	sdtp_chan_if.sink   req,
	sdtp_chan_if.source rsp
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	req_item_t  item_s1;
	logic       valid_s1;
	rsp_item_t  rsp_q;
	logic       rsp_v_q;
	logic       advance;
	logic       take;
	logic       ch_ok;

	cell_cmd_t  cmd   [CHANNELS][SLOTS];
	cell_stat_t stat  [CHANNELS][SLOTS];
	logic [CHANNELS-1:0] ch_sel;
	logic [SLOTS-1:0]    sl_sel;
	logic [SLOTS-1:0]    free;
	logic                found;
	logic [IW-1:0]       index;
	logic [SLOTS-1:0]    grant_oh;
	logic                done;
	logic [31:0]         index_ext;
	rsp_item_t           result;

	// handshake: the input register moves on when the result register frees
	assign advance   = !rsp_v_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;
	assign ch_ok     = 32'(item_s1.channel) < CHANNELS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= req.data;
	end

	// channel and slot decode
	always_comb begin
		for (int c = 0; c < CHANNELS; c++)
			ch_sel[c] = ch_ok && (32'(item_s1.channel) == c);
		for (int s = 0; s < SLOTS; s++)
			sl_sel[s] = (32'(item_s1.slot) == s);
	end

	// free mask and done flag of the addressed channel
	always_comb begin
		free = '0;
		done = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			for (int s = 0; s < SLOTS; s++) begin
				free[s] = free[s] | (ch_sel[c] & ~stat[c][s].busy);
				done    = done | (ch_sel[c] & sl_sel[s] & stat[c][s].expired);
			end
		end
	end

	sdtp_alloc #(.SLOTS(SLOTS)) u_alloc (
		.free  (free),
		.found (found),
		.index (index)
	);

	always_comb begin
		for (int s = 0; s < SLOTS; s++)
			grant_oh[s] = found && (32'(index) == s);
	end

	// per-slot commands, only for a command being processed this cycle
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			for (int s = 0; s < SLOTS; s++) begin
				cmd[c][s] = '0;
				cmd[c][s].delay = item_s1.delay;
				if (valid_s1 && advance && ch_sel[c]) begin
					case (item_s1.mode)
						MODE_TICK:    cmd[c][s].tick = 1'b1;
						MODE_ALLOC:   cmd[c][s].load = grant_oh[s];
						MODE_RELEASE: cmd[c][s].clr  = sl_sel[s];
						MODE_RESTART: cmd[c][s].load = sl_sel[s];
						MODE_CLEAR:   cmd[c][s].clr  = 1'b1;
						default:      cmd[c][s] = cmd[c][s];
					endcase
				end
			end
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		for (genvar s = 0; s < SLOTS; s++) begin : g_sl
			sdtp_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd[c][s]),
				.stat   (stat[c][s])
			);
		end
	end

	// result of the command in the input register
	assign index_ext = 32'(index);
	always_comb begin
		result = '0;
		case (item_s1.mode)
			MODE_ALLOC: begin
				result.alloc_failed = !(ch_ok && found);
				if (ch_ok && found)
					result.granted_slot = index_ext[GRANT_W-1:0];
			end
			MODE_QUERY: result.done_res = done;
			default:    result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (advance) begin
			rsp_v_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			rsp_q <= result;
	end

	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;
endmodule

// ----- hdl/sdtp_checker.sv -----
// Port-level checks for the delay timer pool, bound to the top level.
// Depends on sdtp_pkg for widths.
module sdtp_checker import sdtp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [GRANT_W-1:0] granted_slot,
	input logic               alloc_failed,
	input logic               done_res
);
	// a pending result holds until its transaction completes
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_slot)
		&& $stable(alloc_failed) && $stable(done_res))
		else $error("response dropped or changed while stalled");

	// a failed allocate carries no slot and no done flag
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && alloc_failed |-> granted_slot == '0 && !done_res)
		else $error("failed allocate with nonzero fields");

	// a query result is never an allocate result
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> !alloc_failed && granted_slot == '0)
		else $error("done flag mixed with allocate fields");

	// with the result register empty the block always takes a command
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused with empty result register");
endmodule

bind software_delay_timer_pool sdtp_checker u_sdtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.granted_slot (rsp.data.granted_slot),
	.alloc_failed (rsp.data.alloc_failed),
	.done_res     (rsp.data.done_res)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for software_delay_timer_pool: directed and random commands on req,
// per-field checking of every rsp transaction against an in-bench slot pool predictor.
// Depends on sdtp_pkg, sdtp_chan_if and software_delay_timer_pool.
module tb;
	import sdtp_pkg::*;

	localparam int N_SLOTS      = 16;
	localparam int N_CHAN       = 4;
	localparam int POOL_DEPTH   = N_SLOTS * N_CHAN;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;

	// mode codes the block does not decode
	localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd7;

	logic clk;
	logic arst_n;

	sdtp_chan_if #(.T(req_item_t)) req_if ();
	sdtp_chan_if #(.T(rsp_item_t)) rsp_if ();

	software_delay_timer_pool #(
		.SLOTS(N_SLOTS),
		.CHANNELS(N_CHAN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// predictor copy of the slot pool
	logic [DELAY_W-1:0] count_q [POOL_DEPTH];
	bit                 busy_q  [POOL_DEPTH];
	bit                 done_q  [POOL_DEPTH];

	rsp_item_t expected_rsp_q [$];
	int        err_count;
	int        send_idle_pct;
	int        rcv_stall_pct;
	int        quiet_cycles;
	bit        req_held;

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	function automatic req_item_t make_cmd(logic [MODE_W-1:0] mode, int ch, int sl,
			logic [DELAY_W-1:0] dly);
		req_item_t c;
		c.mode    = mode;
		c.channel = ch[CHAN_W-1:0];
		c.slot    = sl[SLOT_W-1:0];
		c.delay   = dly;
		return c;
	endfunction

	// apply one command to the pool and return the result it must produce
	function automatic rsp_item_t predict_cmd(req_item_t c);
		rsp_item_t r;
		int base;
		int e;
		bit ch_ok;
		bit sl_ok;
		r     = '0;
		ch_ok = int'(c.channel) < N_CHAN;
		sl_ok = int'(c.slot) < N_SLOTS;
		base  = int'(c.channel) * N_SLOTS;
		e     = base + int'(c.slot);
		case (c.mode)
			MODE_TICK: begin
				if (ch_ok) begin
					for (int i = 0; i < N_SLOTS; i++) begin
						if (busy_q[base+i] && count_q[base+i] != '0)
							count_q[base+i] = count_q[base+i] - DELAY_W'(1);
						if (busy_q[base+i] && count_q[base+i] == '0)
							done_q[base+i] = 1'b1;
					end
				end
			end
			MODE_ALLOC: begin
				r.alloc_failed = 1'b1;
				if (ch_ok) begin
					for (int i = 0; i < N_SLOTS; i++) begin
						if (r.alloc_failed && !busy_q[base+i]) begin
							count_q[base+i] = c.delay;
							busy_q[base+i]  = 1'b1;
							done_q[base+i]  = 1'b0;
							r.granted_slot  = i[GRANT_W-1:0];
							r.alloc_failed  = 1'b0;
						end
					end
				end
			end
			MODE_QUERY: begin
				if (ch_ok && sl_ok)
					r.done_res = done_q[e];
			end
			MODE_RELEASE: begin
				if (ch_ok && sl_ok) begin
					count_q[e] = '0;
					busy_q[e]  = 1'b0;
					done_q[e]  = 1'b0;
				end
			end
			MODE_RESTART: begin
				if (ch_ok && sl_ok) begin
					count_q[e] = c.delay;
					busy_q[e]  = 1'b1;
					done_q[e]  = 1'b0;
				end
			end
			MODE_CLEAR: begin
				if (ch_ok) begin
					for (int i = 0; i < N_SLOTS; i++) begin
						count_q[base+i] = '0;
						busy_q[base+i]  = 1'b0;
						done_q[base+i]  = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// drive one transaction on req; optional random gap afterwards
	task automatic send_cmd(req_item_t c);
		req_if.data  <= c;
		req_if.valid <= 1'b1;
		req_held = 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		expected_rsp_q.push_back(predict_cmd(c));
		if ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			req_held = 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// hold off the sender until every outstanding result is back
	task automatic wait_all_results();
		if (req_held) begin
			req_if.valid <= 1'b0;
			req_held = 1'b0;
		end
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(int send_pct, int stall_pct);
		send_idle_pct = send_pct;
		rcv_stall_pct = stall_pct;
	endtask

	// random command, biased toward slots that allocate hands out
	function automatic req_item_t rand_cmd();
		int pick;
		int sl;
		int ch;
		logic [DELAY_W-1:0] dly;
		logic [MODE_W-1:0] mode;
		pick = $urandom_range(99);
		ch   = $urandom_range(N_CHAN - 1);
		sl   = ($urandom_range(99) < 70) ? $urandom_range(5) : $urandom_range(N_SLOTS - 1);
		case ($urandom_range(9))
			0:       dly = DELAY_W'($urandom);
			1:       dly = '1;
			default: dly = DELAY_W'($urandom_range(6));
		endcase
		if (pick < 26)
			mode = MODE_ALLOC;
		else if (pick < 52)
			mode = MODE_TICK;
		else if (pick < 72)
			mode = MODE_QUERY;
		else if (pick < 82)
			mode = MODE_RELEASE;
		else if (pick < 92)
			mode = MODE_RESTART;
		else if (pick < 95)
			mode = MODE_CLEAR;
		else
			mode = ($urandom_range(1) != 0) ? MODE_RSVD_A : MODE_RSVD_B;
		return make_cmd(mode, ch, sl, dly);
	endfunction

	// result checker and receiver stall generator
	always @(posedge clk) begin
		rsp_item_t want;
		if (rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("unexpected result, granted_slot", rsp_if.data.granted_slot, 0);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp_if.data.granted_slot !== want.granted_slot)
					report_mismatch("granted_slot", rsp_if.data.granted_slot,
						want.granted_slot);
				if (rsp_if.data.alloc_failed !== want.alloc_failed)
					report_mismatch("alloc_failed", rsp_if.data.alloc_failed,
						want.alloc_failed);
				if (rsp_if.data.done_res !== want.done_res)
					report_mismatch("done_res", rsp_if.data.done_res, want.done_res);
			end
		end
		rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// edges of fields, every mode and the corner cases
	task automatic test_directed();
		set_idling(0, 0);
		send_cmd(make_cmd(MODE_ALLOC, 0, 0, 16'd0));
		send_cmd(make_cmd(MODE_QUERY, 0, 0, 16'd0));
		send_cmd(make_cmd(MODE_TICK, 0, 0, 16'd0));
		send_cmd(make_cmd(MODE_QUERY, 0, 0, 16'd0));
		send_cmd(make_cmd(MODE_ALLOC, 3, 15, 16'hFFFF));
		send_cmd(make_cmd(MODE_TICK, 3, 0, 16'hFFFF));
		send_cmd(make_cmd(MODE_QUERY, 3, 0, 16'd0));
		// restart of a free slot makes it busy
		send_cmd(make_cmd(MODE_RESTART, 3, 15, 16'd1));
		send_cmd(make_cmd(MODE_TICK, 3, 0, 16'd0));
		send_cmd(make_cmd(MODE_QUERY, 3, 15, 16'd0));
		send_cmd(make_cmd(MODE_RELEASE, 3, 15, 16'd0));
		send_cmd(make_cmd(MODE_QUERY, 3, 15, 16'd0));
		// undecoded modes with all other bits set
		send_cmd(make_cmd(MODE_RSVD_A, 3, 15, 16'hFFFF));
		send_cmd(make_cmd(MODE_RSVD_B, 3, 15, 16'hFFFF));
		send_cmd(make_cmd(MODE_CLEAR, 0, 0, 16'd0));
		send_cmd(make_cmd(MODE_QUERY, 0, 0, 16'd0));
		send_cmd(make_cmd(MODE_ALLOC, 0, 0, 16'd2));
		send_cmd(make_cmd(MODE_RELEASE, 2, 5, 16'd0));
		send_cmd(make_cmd(MODE_TICK, 1, 0, 16'd0));
		send_cmd(make_cmd(MODE_QUERY, 2, 7, 16'd0));
		send_cmd(make_cmd(MODE_RESTART, 0, 0, 16'hAAAA));
		send_cmd(make_cmd(MODE_QUERY, 0, 0, 16'd0));
		wait_all_results();
	endtask

	// fill every channel until allocate fails, then reuse a freed slot
	task automatic test_pool_exhaust();
		set_idling(0, 0);
		for (int ch = 0; ch < N_CHAN; ch++) begin
			for (int i = 0; i <= N_SLOTS; i++)
				send_cmd(make_cmd(MODE_ALLOC, ch, 0, 16'($urandom_range(3))));
			send_cmd(make_cmd(MODE_RELEASE, ch, 7, 16'd0));
			send_cmd(make_cmd(MODE_ALLOC, ch, 0, 16'($urandom)));
			send_cmd(make_cmd(MODE_ALLOC, ch, 0, 16'd1));
		end
		wait_all_results();
	endtask

	// sender stops until the block has returned everything
	task automatic test_pause_for_results();
		set_idling(0, 0);
		for (int i = 0; i < 6; i++)
			send_cmd(make_cmd(MODE_TICK, i % N_CHAN, 0, 16'd0));
		wait_all_results();
		for (int i = 0; i < 6; i++)
			send_cmd(make_cmd(MODE_QUERY, i % N_CHAN, i, 16'd0));
		wait_all_results();
	endtask

	task automatic test_random(int n_items, int send_pct, int stall_pct);
		set_idling(send_pct, stall_pct);
		for (int i = 0; i < n_items; i++)
			send_cmd(rand_cmd());
		wait_all_results();
	endtask

	initial begin
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		req_held      = 1'b0;
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		for (int e = 0; e < POOL_DEPTH; e++) begin
			count_q[e] = '0;
			busy_q[e]  = 1'b0;
			done_q[e]  = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pool_exhaust();
		test_pause_for_results();
		test_random(120, 0, 0);
		test_random(80, 79, 0);
		test_random(80, 0, 79);
		test_random(80, 28, 28);

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
